// ===== rtl/pnrs_pkg.sv =====
// shared types and constants for the periodic note repeat scheduler
package pnrs_pkg;

  localparam int SLOTS  = 20;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_STOP_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_NOT_HELD    = 2'd2,
    ST_UNUSED      = 2'd3
  } status_t;

  localparam logic KIND_STRIKE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] now_ms;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] interval_ms;
    logic [15:0] strike_count;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  strike_note;
    logic [6:0]  strike_velocity;
    status_t     status;
    logic        last;
  } rsp_t;

endpackage

// ===== rtl/periodic_note_repeat_scheduler.sv =====
// top level of the periodic note repeat scheduler: slot table and scan sequencer
//
// usage:
//   req channel (req, req_valid, req_ready) carries one command: tick, start,
//   stop or stop all. rsp channel (rsp, rsp_valid, rsp_ready) returns the
//   results of that command: zero or more strike events (ticks only, in slot
//   order) and then one status result with last set.
//   tick, start and stop walk the slot table one slot per cycle, unless a
//   stalled receiver holds the scan, with a single compare/add/decrement
//   datapath; req_ready stays low from the taken request until the status
//   result is placed in the output register, so the block takes no new
//   request while a scan runs. stop all has no scan and drops req_ready only
//   until its status result is placed.
//   results sit in one output register; a stalled receiver holds the scan at
//   the current slot until the waiting result is taken, nothing is dropped.
//   the block can take the next request while the last status still waits.
//   reset (rst, synchronous) frees every slot and empties the output register;
//   slot contents other than the active flags are not cleared.
module periodic_note_repeat_scheduler (
  input  logic            clk,
  input  logic            rst,
  input  pnrs_pkg::req_t  req,
  input  logic            req_valid,
  output logic            req_ready,
  output pnrs_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_ready
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_STATUS = 3'b100
  } state_t;

  localparam pnrs_pkg::slot_idx_t LAST_IDX = pnrs_pkg::SLOT_W'(pnrs_pkg::SLOTS - 1);

  state_t state;

  // slot table; only the active flags are reset
  logic        slot_active    [pnrs_pkg::SLOTS];
  logic [6:0]  slot_note      [pnrs_pkg::SLOTS];
  logic [6:0]  slot_velocity  [pnrs_pkg::SLOTS];
  logic [31:0] slot_period    [pnrs_pkg::SLOTS];
  logic [15:0] slot_remaining [pnrs_pkg::SLOTS];
  logic [31:0] slot_due_time  [pnrs_pkg::SLOTS];

  // latched request
  pnrs_pkg::req_t cur;

  // scan position and search results
  pnrs_pkg::slot_idx_t idx;
  logic                match_hit;
  pnrs_pkg::slot_idx_t match_idx;
  logic                free_hit;
  pnrs_pkg::slot_idx_t free_idx;

  // shared datapath on the slot under the scan pointer
  logic        cur_active;
  logic        cur_note_eq;
  logic        due;
  logic [31:0] next_due;
  logic [15:0] remaining_dec;
  logic        out_free;
  logic        strike;
  logic        advance;

  // target slot and status of a start or stop
  logic                write_hit;
  pnrs_pkg::slot_idx_t write_idx;
  pnrs_pkg::status_t   fin_status;

  assign cur_active    = slot_active[idx];
  assign cur_note_eq   = cur_active && (slot_note[idx] == cur.note);
  assign due           = cur_active && (cur.now_ms >= slot_due_time[idx]);
  assign next_due      = cur.now_ms + slot_period[idx];
  assign remaining_dec = slot_remaining[idx] - 16'd1;

  // output register can take a new result this cycle
  assign out_free = !rsp_valid || rsp_ready;

  assign strike  = (state == S_SCAN) && (cur.command == pnrs_pkg::CMD_TICK) && due;
  // a strike that cannot be placed holds the scan on this slot
  assign advance = (state == S_SCAN) && (!strike || out_free);

  assign req_ready = (state == S_IDLE);

  // start reuses the slot of the same note, else the first free one; stop targets the slot of the same note
  always_comb begin
    write_hit  = 1'b0;
    write_idx  = match_idx;
    fin_status = pnrs_pkg::ST_OK;
    case (cur.command)
      pnrs_pkg::CMD_START: begin
        if (match_hit) begin
          write_hit = 1'b1;
          write_idx = match_idx;
        end else if (free_hit) begin
          write_hit = 1'b1;
          write_idx = free_idx;
        end else begin
          fin_status = pnrs_pkg::ST_NO_FREE;
        end
      end
      pnrs_pkg::CMD_STOP: begin
        if (match_hit) begin
          write_hit = 1'b1;
        end else begin
          fin_status = pnrs_pkg::ST_NOT_HELD;
        end
      end
      default: begin
        fin_status = pnrs_pkg::ST_OK;
      end
    endcase
  end

  // slot table payload, no reset
  always_ff @(posedge clk) begin
    if (strike && out_free) begin
      slot_due_time[idx] <= next_due;
      if (slot_remaining[idx] != 16'd0) begin
        slot_remaining[idx] <= remaining_dec;
      end
    end
    if ((state == S_STATUS) && out_free && write_hit &&
        (cur.command == pnrs_pkg::CMD_START)) begin
      slot_note[write_idx]      <= cur.note;
      slot_velocity[write_idx]  <= cur.velocity;
      slot_period[write_idx]    <= cur.interval_ms;
      slot_remaining[write_idx] <= cur.strike_count;
      slot_due_time[write_idx]  <= cur.now_ms;
    end
  end

  // request latch and search bookkeeping
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur       <= req;
      idx       <= '0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      match_idx <= '0;
      free_idx  <= '0;
    end else if (advance) begin
      if (cur_note_eq && !match_hit) begin
        match_hit <= 1'b1;
        match_idx <= idx;
      end
      if (!cur_active && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= idx;
      end
      if (idx != LAST_IDX) begin
        idx <= idx + pnrs_pkg::SLOT_W'(1);
      end
    end
  end

  // sequencer, active flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < pnrs_pkg::SLOTS; i++) begin
        slot_active[i] <= 1'b0;
      end
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            // stop all has nothing to search
            state <= (req.command == pnrs_pkg::CMD_STOP_ALL) ? S_STATUS : S_SCAN;
          end
        end
        S_SCAN: begin
          if (strike && out_free) begin
            rsp_valid           <= 1'b1;
            rsp.kind            <= pnrs_pkg::KIND_STRIKE;
            rsp.strike_note     <= slot_note[idx];
            rsp.strike_velocity <= slot_velocity[idx];
            rsp.status          <= pnrs_pkg::ST_OK;
            rsp.last            <= 1'b0;
            // a count that runs out frees the slot
            if (slot_remaining[idx] == 16'd1) begin
              slot_active[idx] <= 1'b0;
            end
          end
          if (advance && (idx == LAST_IDX)) begin
            state <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            rsp_valid           <= 1'b1;
            rsp.kind            <= pnrs_pkg::KIND_STATUS;
            rsp.strike_note     <= '0;
            rsp.strike_velocity <= '0;
            rsp.status          <= fin_status;
            rsp.last            <= 1'b1;
            case (cur.command)
              pnrs_pkg::CMD_START: begin
                if (write_hit) begin
                  slot_active[write_idx] <= 1'b1;
                end
              end
              pnrs_pkg::CMD_STOP: begin
                if (write_hit) begin
                  slot_active[write_idx] <= 1'b0;
                end
              end
              pnrs_pkg::CMD_STOP_ALL: begin
                for (int i = 0; i < pnrs_pkg::SLOTS; i++) begin
                  slot_active[i] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
